// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for concurrent checks on clk with reset rst_n active low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds on every clock edge out of reset.
`define MBSS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A consequence that holds on the same edge as its antecedent.
`define MBSS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mbss_pkg.sv =====
// ----------------------------------------------------------------------------
// mbss_pkg
// Types and constants shared by the masked byte signature search.
// ----------------------------------------------------------------------------
package mbss_pkg;

    localparam int PATTERN_MAX_DEFAULT = 64;

    localparam int INDEX_W     = 6;
    localparam int LENGTH_W    = 7;
    localparam int OFFSET_W    = 31;
    localparam int SEEN_W      = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 31;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;
    localparam logic [SEEN_W-1:0]   SEEN_MAX   = '1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SCAN = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_OFFSET    = 1'b1;

    typedef struct packed {
        logic               command;
        logic [7:0]         byte_value;
        logic               is_wildcard;
        logic [INDEX_W-1:0] pattern_index;
        logic               last_byte;
    } item_t;

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] match_offset;
    } result_t;

    typedef struct packed {
        logic  is_scan;
        item_t item;
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } head_t;

endpackage

// ===== rtl/masked_byte_signature_search.sv =====
// ----------------------------------------------------------------------------
// masked_byte_signature_search
// Finds the first match of a wildcard byte signature in a byte stream.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle, loads and scans alike, while
// its queue is not full; a result passes from the queue through the match
// stage register and the output register. The whole pattern is compared
// against the byte window in parallel, so the rate is set by the single
// match stage. A write to pattern_length starts a rebuild of the reversed
// pattern copy from the pattern memory, one entry per cycle; items accepted
// meanwhile wait in the two-entry queue.
`include "assert_macros.svh"

module masked_byte_signature_search #(
    parameter int PATTERN_MAX = mbss_pkg::PATTERN_MAX_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  mbss_pkg::item_t                    item,
    output logic                               result_valid,
    input  logic                               result_stall,
    output mbss_pkg::result_t                  result,
    input  logic                               cfg_write,
    input  logic [mbss_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mbss_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mbss_pkg::*;

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int LC_W  = (LEN_W > LENGTH_W) ? LEN_W : LENGTH_W;

    logic [LEN_W-1:0]    used_len_reg, used_len_next;
    logic [OFFSET_W-1:0] base_offset_reg, base_offset_next;
    logic                rebuild_reg;
    logic [LC_W-1:0]     len_raw;
    logic [LC_W-1:0]     len_clamped;
    head_t               head;
    logic                pop;

    assign len_raw = LC_W'(cfg_data[LENGTH_W-1:0]);

    always_comb
    begin
        if (len_raw == '0)
        begin
            len_clamped = LC_W'(1);
        end
        else if (len_raw > LC_W'(PATTERN_MAX))
        begin
            len_clamped = LC_W'(PATTERN_MAX);
        end
        else
        begin
            len_clamped = len_raw;
        end

        used_len_next    = used_len_reg;
        base_offset_next = base_offset_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PATTERN_LENGTH: used_len_next    = LEN_W'(len_clamped);
                CFG_BASE_OFFSET:    base_offset_next = cfg_data[OFFSET_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_len_reg    <= LEN_W'(1);
            base_offset_reg <= '0;
            rebuild_reg     <= 1'b0;
        end
        else
        begin
            used_len_reg    <= used_len_next;
            base_offset_reg <= base_offset_next;
            rebuild_reg     <= cfg_write && (cfg_index == CFG_PATTERN_LENGTH);
        end
    end

    mbss_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .head       (head),
        .pop        (pop)
    );

    mbss_back #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .used_len     (used_len_reg),
        .base_offset  (base_offset_reg),
        .rebuild      (rebuild_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    `MBSS_ASSERT_ALWAYS(a_length_in_range, (used_len_reg != '0) && (32'(used_len_reg) <= PATTERN_MAX), "Used pattern length is out of range.")
    `MBSS_ASSERT_IMP(a_not_found_zero, result_valid && !result.found, result.match_offset == '0, "A not-found item carries a non-zero offset.")
    `MBSS_ASSERT_IMP(a_offset_above_base, result_valid && result.found, result.match_offset >= base_offset_reg, "A match offset lies below the base offset.")

endmodule

// ===== rtl/mbss_front.sv =====
// ----------------------------------------------------------------------------
// mbss_front
// Accepts items, drops loads outside the pattern store and queues the rest.
// ----------------------------------------------------------------------------
module mbss_front #(
    parameter int PATTERN_MAX = mbss_pkg::PATTERN_MAX_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  mbss_pkg::item_t item,
    output mbss_pkg::head_t head,
    input  logic            pop
);
    import mbss_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_t              q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             is_scan;
    logic             load_en;
    logic             push;
    logic             do_pop;

    assign item_stall = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_scan    = (item.command == CMD_SCAN);
    assign load_en    = (item.command == CMD_LOAD) && (int'(item.pattern_index) < PATTERN_MAX);
    assign push       = item_valid && !item_stall && (is_scan || load_en);
    assign do_pop     = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.op    = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{is_scan: is_scan, item: item};
        end
    end

endmodule

// ===== rtl/mbss_back.sv =====
// ----------------------------------------------------------------------------
// mbss_back
// Executes queued items: pattern loads, window shifts, matching and results.
// ----------------------------------------------------------------------------
module mbss_back #(
    parameter int PATTERN_MAX = mbss_pkg::PATTERN_MAX_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mbss_pkg::head_t                      head,
    output logic                                 pop,
    input  logic [$clog2(PATTERN_MAX + 1)-1:0]   used_len,
    input  logic [mbss_pkg::OFFSET_W-1:0]        base_offset,
    input  logic                                 rebuild,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output mbss_pkg::result_t                    result
);
    import mbss_pkg::*;

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int EXT_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
    localparam int CW    = ((EXT_W > LEN_W) ? EXT_W : LEN_W) + 1;

    // Raw pattern by load index, and a copy reversed so that position zero
    // faces the newest window byte.
    logic [8:0]        raw_mem [PATTERN_MAX];
    logic [8:0]        rd_data_reg;
    logic [7:0]        rp_byte_reg [PATTERN_MAX];
    logic              rp_wild_reg [PATTERN_MAX];
    logic [7:0]        win_reg [PATTERN_MAX];
    logic [7:0]        win_next [PATTERN_MAX];

    logic              sweep_active_reg, sweep_active_next;
    logic [IDX_W-1:0]  sweep_cnt_reg, sweep_cnt_next;
    logic              rd_pend_reg;
    logic [IDX_W-1:0]  rd_slot_reg;
    logic [IDX_W-1:0]  sweep_addr;
    logic              busy;

    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic              reported_reg, reported_next;
    logic [SEEN_W-1:0] seen_inc;
    logic [SEEN_W:0]   diff;
    logic              all_ok;
    logic              hit;
    logic              emit;

    logic              a_valid_reg, a_valid_next;
    logic              a_found_reg;
    logic [SEEN_W-1:0] a_start_reg;
    logic              result_valid_reg, result_valid_next;
    result_t           result_reg;
    logic              out_ready;
    logic              a_adv;
    logic              scan_pop;
    logic              load_pop;
    logic [EXT_W-1:0]  idx_ext;
    logic [IDX_W-1:0]  load_addr;
    logic              load_rp_we;
    logic [IDX_W-1:0]  load_rp_addr;
    logic [SEEN_W:0]   sum;
    logic [OFFSET_W-1:0] offset_sat;

    assign busy      = sweep_active_reg || rd_pend_reg || rebuild;
    assign out_ready = !result_valid_reg || !result_stall;
    assign a_adv     = !a_valid_reg || out_ready;
    assign pop       = head.valid && a_adv && !busy;
    assign scan_pop  = pop && head.op.is_scan;
    assign load_pop  = pop && !head.op.is_scan;

    assign idx_ext      = EXT_W'(head.op.item.pattern_index);
    assign load_addr    = idx_ext[IDX_W-1:0];
    assign load_rp_we   = load_pop && (CW'(idx_ext) < CW'(used_len));
    assign load_rp_addr = IDX_W'(CW'(used_len) - CW'(1) - CW'(idx_ext));
    assign sweep_addr   = IDX_W'(CW'(used_len) - CW'(1) - CW'(sweep_cnt_reg));

    always_comb
    begin
        sweep_active_next = sweep_active_reg;
        sweep_cnt_next    = sweep_cnt_reg;
        if (rebuild)
        begin
            sweep_active_next = 1'b1;
            sweep_cnt_next    = '0;
        end
        else if (sweep_active_reg)
        begin
            if (CW'(sweep_cnt_reg) == CW'(used_len) - CW'(1))
            begin
                sweep_active_next = 1'b0;
            end
            sweep_cnt_next = sweep_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_active_reg <= 1'b0;
            sweep_cnt_reg    <= '0;
            rd_pend_reg      <= 1'b0;
        end
        else
        begin
            sweep_active_reg <= sweep_active_next;
            sweep_cnt_reg    <= sweep_cnt_next;
            rd_pend_reg      <= sweep_active_reg && !rebuild;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_pop)
        begin
            raw_mem[load_addr] <= {head.op.item.is_wildcard, head.op.item.byte_value};
        end
        rd_data_reg <= raw_mem[sweep_addr];
        rd_slot_reg <= sweep_cnt_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
        begin
            rp_wild_reg[rd_slot_reg] <= rd_data_reg[8];
            rp_byte_reg[rd_slot_reg] <= rd_data_reg[7:0];
        end
        else if (load_rp_we)
        begin
            rp_wild_reg[load_rp_addr] <= head.op.item.is_wildcard;
            rp_byte_reg[load_rp_addr] <= head.op.item.byte_value;
        end
    end

    always_comb
    begin
        for (int j = 0; j < PATTERN_MAX - 1; j++)
        begin
            win_next[j] = win_reg[j + 1];
        end
        win_next[PATTERN_MAX - 1] = head.op.item.byte_value;
    end

    always_ff @(posedge clk)
    begin
        if (scan_pop)
        begin
            win_reg <= win_next;
        end
    end

    always_comb
    begin
        all_ok = 1'b1;
        for (int d = 0; d < PATTERN_MAX; d++)
        begin
            if ((CW'(d) < CW'(used_len)) && !rp_wild_reg[d]
                && (rp_byte_reg[d] != win_next[PATTERN_MAX - 1 - d]))
            begin
                all_ok = 1'b0;
            end
        end
    end

    assign seen_inc = (seen_reg == SEEN_MAX) ? seen_reg : seen_reg + 1'b1;
    assign diff     = {1'b0, seen_inc} - (SEEN_W + 1)'(used_len);
    assign hit      = !reported_reg && !diff[SEEN_W] && all_ok;
    assign emit     = hit || (head.op.item.last_byte && !reported_reg);

    always_comb
    begin
        seen_next     = seen_reg;
        reported_next = reported_reg;
        if (scan_pop)
        begin
            if (head.op.item.last_byte)
            begin
                seen_next     = '0;
                reported_next = 1'b0;
            end
            else
            begin
                seen_next     = seen_inc;
                reported_next = reported_reg || hit;
            end
        end

        a_valid_next = a_valid_reg;
        if (scan_pop)
        begin
            a_valid_next = emit;
        end
        else if (a_adv)
        begin
            a_valid_next = 1'b0;
        end

        result_valid_next = out_ready ? a_valid_reg : result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg         <= '0;
            reported_reg     <= 1'b0;
            a_valid_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg         <= seen_next;
            reported_reg     <= reported_next;
            a_valid_reg      <= a_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign sum        = (SEEN_W + 1)'(base_offset) + (SEEN_W + 1)'(a_start_reg);
    assign offset_sat = (|sum[SEEN_W:OFFSET_W]) ? OFFSET_MAX : sum[OFFSET_W-1:0];

    always_ff @(posedge clk)
    begin
        if (scan_pop)
        begin
            a_found_reg <= hit;
            a_start_reg <= diff[SEEN_W-1:0];
        end
        if (a_valid_reg && out_ready)
        begin
            result_reg.found        <= a_found_reg;
            result_reg.match_offset <= a_found_reg ? offset_sat : '0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
